@@ rtl/point_crop_and_level_filter_macros.svh @@
// Assertion macros shared by the verification checker of the point crop filter
`ifndef POINT_CROP_AND_LEVEL_FILTER_MACROS_SVH
`define POINT_CROP_AND_LEVEL_FILTER_MACROS_SVH

// Same-cycle implication, ignored during reset
`define PCLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored during reset
`define PCLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well
`define PCLF_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pclf_pkg.sv @@
// Shared types, constants and helpers of the point crop and level filter
package pclf_pkg;

    localparam int PCLF_ADDR_W = 6;
    localparam int PCLF_DATA_W = 64;

    typedef enum logic [2:0] {
        REG_ROT_ROW_X     = 3'd0,
        REG_ROT_ROW_Y     = 3'd1,
        REG_ROT_ROW_Z     = 3'd2,
        REG_PRE_X_LIMITS  = 3'd3,
        REG_PRE_YZ_LIMITS = 3'd4,
        REG_LVL_X_LIMITS  = 3'd5,
        REG_LVL_YZ_LIMITS = 3'd6,
        REG_EGO_ENABLE    = 3'd7
    } t_reg_idx;

    localparam logic [47:0] RST_ROT_ROW_X     = 48'd16384;
    localparam logic [47:0] RST_ROT_ROW_Y     = 48'd1073741824;
    localparam logic [47:0] RST_ROT_ROW_Z     = 48'd70368744177664;
    localparam logic [31:0] RST_PRE_X_LIMITS  = 32'd393216000;
    localparam logic [31:0] RST_PRE_YZ_LIMITS = 32'd19662300;
    localparam logic [31:0] RST_LVL_X_LIMITS  = 32'd393216000;
    localparam logic [47:0] RST_LVL_YZ_LIMITS = 48'd1288490190300;
    localparam logic        RST_EGO_ENABLE    = 1'b1;

    localparam logic signed [15:0] EGO_X_MIN = -16'sd250;
    localparam logic signed [15:0] EGO_X_MAX = 16'sd380;
    localparam logic signed [15:0] EGO_Y_MIN = -16'sd190;
    localparam logic signed [15:0] EGO_Y_MAX = 16'sd190;
    localparam logic signed [15:0] EGO_Z_MIN = -16'sd150;
    localparam logic signed [15:0] EGO_Z_MAX = 16'sd550;

    localparam int FRAC_BITS = 14;

    typedef struct packed {
        logic adv_prod;
        logic adv_sum;
    } t_pipe_ctl;

    function automatic logic signed [16:0] abs17(input logic signed [15:0] v);
        logic signed [16:0] ext;
        ext = {v[15], v};
        return v[15] ? -ext : ext;
    endfunction

    function automatic logic signed [16:0] sext17(input logic [15:0] v);
        return $signed({v[15], v});
    endfunction

endpackage

@@ rtl/pclf_intf.sv @@
// Point input and leveled point output channel interfaces
interface pclf_in_if;
    logic               valid;
    logic               ready;
    logic               point_ok;
    logic signed [15:0] body_x;
    logic signed [15:0] body_y;
    logic signed [15:0] body_z;

    modport source (output valid, point_ok, body_x, body_y, body_z, input ready);
    modport sink (input valid, point_ok, body_x, body_y, body_z, output ready);
endinterface

interface pclf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] level_x;
    logic signed [15:0] level_y;
    logic signed [15:0] level_z;

    modport source (output valid, level_x, level_y, level_z, input ready);
    modport sink (input valid, level_x, level_y, level_z, output ready);
endinterface

@@ rtl/pclf_rot_row.sv @@
// One row of the leveling rotation: registered products, then sum, shift and saturate
module pclf_rot_row (
    input  logic                i_clk,
    input  pclf_pkg::t_pipe_ctl i_ctl,
    input  logic [47:0]         i_row,
    input  logic signed [15:0]  i_x,
    input  logic signed [15:0]  i_y,
    input  logic signed [15:0]  i_z,
    output logic signed [15:0]  o_level
);

    logic signed [31:0] r_p0, r_p1, r_p2;
    logic signed [32:0] w_sum;
    logic signed [18:0] w_quot;
    logic signed [15:0] n_level;
    logic signed [15:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_prod) begin
            r_p0 <= $signed(i_row[15:0]) * i_x;
            r_p1 <= $signed(i_row[31:16]) * i_y;
            r_p2 <= $signed(i_row[47:32]) * i_z;
        end
    end

    always_comb begin
        w_sum  = 33'(r_p0) + 33'(r_p1) + 33'(r_p2);
        w_quot = w_sum[32:pclf_pkg::FRAC_BITS];
        if (w_quot[18:15] == {4{w_quot[15]}}) begin
            n_level = w_quot[15:0];
        end else if (w_quot[18]) begin
            n_level = 16'sh8000;
        end else begin
            n_level = 16'sh7fff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_sum) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

@@ rtl/point_crop_and_level_filter.sv @@
// Lidar point crop-box filter with ego removal, Q1.14 leveling and leveled box crop
// Takes one point per clock while the output is not stalled and returns a leveled point, or
// nothing, through its input register, product register, sum and saturate register and
// output register, each advancing as long as the stage after it is empty or moving. Invalid
// points, points outside the pre-crop box and, with ego removal enabled, points inside the
// ego box are dropped before the rotation; rotated points outside the leveled box are
// dropped at the output register. Configuration sits on an APB port with 64-bit data,
// register i at byte address 8*i; write it only while no point is in flight.
module point_crop_and_level_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pclf_in_if.sink                            i_in,
    pclf_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pclf_pkg::PCLF_ADDR_W-1:0]   paddr,
    input  logic [pclf_pkg::PCLF_DATA_W-1:0]   pwdata,
    output logic [pclf_pkg::PCLF_DATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [47:0] r_rot_row_x, r_rot_row_y, r_rot_row_z;
    logic [31:0] r_pre_x_limits, r_pre_yz_limits, r_lvl_x_limits;
    logic [47:0] r_lvl_yz_limits;
    logic        r_ego_enable;

    pclf_pkg::t_reg_idx w_idx;
    logic               w_wr;

    logic               r_v1, r_v2, r_v3, r_out_valid;
    logic signed [15:0] r_x1, r_y1, r_z1;
    logic signed [15:0] r_out_x, r_out_y, r_out_z;
    logic signed [15:0] w_lx, w_ly, w_lz;
    logic               w_rdy1, w_rdy2, w_rdy3, w_rdy_out;
    logic               w_pre_pass, w_ego_hit, w_lvl_pass;
    pclf_pkg::t_pipe_ctl w_ctl;

    assign w_idx  = pclf_pkg::t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_row_x     <= pclf_pkg::RST_ROT_ROW_X;
            r_rot_row_y     <= pclf_pkg::RST_ROT_ROW_Y;
            r_rot_row_z     <= pclf_pkg::RST_ROT_ROW_Z;
            r_pre_x_limits  <= pclf_pkg::RST_PRE_X_LIMITS;
            r_pre_yz_limits <= pclf_pkg::RST_PRE_YZ_LIMITS;
            r_lvl_x_limits  <= pclf_pkg::RST_LVL_X_LIMITS;
            r_lvl_yz_limits <= pclf_pkg::RST_LVL_YZ_LIMITS;
            r_ego_enable    <= pclf_pkg::RST_EGO_ENABLE;
        end else if (w_wr) begin
            case (w_idx)
                pclf_pkg::REG_ROT_ROW_X:     r_rot_row_x     <= pwdata[47:0];
                pclf_pkg::REG_ROT_ROW_Y:     r_rot_row_y     <= pwdata[47:0];
                pclf_pkg::REG_ROT_ROW_Z:     r_rot_row_z     <= pwdata[47:0];
                pclf_pkg::REG_PRE_X_LIMITS:  r_pre_x_limits  <= pwdata[31:0];
                pclf_pkg::REG_PRE_YZ_LIMITS: r_pre_yz_limits <= pwdata[31:0];
                pclf_pkg::REG_LVL_X_LIMITS:  r_lvl_x_limits  <= pwdata[31:0];
                pclf_pkg::REG_LVL_YZ_LIMITS: r_lvl_yz_limits <= pwdata[47:0];
                pclf_pkg::REG_EGO_ENABLE:    r_ego_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pclf_pkg::REG_ROT_ROW_X:     prdata = {16'd0, r_rot_row_x};
            pclf_pkg::REG_ROT_ROW_Y:     prdata = {16'd0, r_rot_row_y};
            pclf_pkg::REG_ROT_ROW_Z:     prdata = {16'd0, r_rot_row_z};
            pclf_pkg::REG_PRE_X_LIMITS:  prdata = {32'd0, r_pre_x_limits};
            pclf_pkg::REG_PRE_YZ_LIMITS: prdata = {32'd0, r_pre_yz_limits};
            pclf_pkg::REG_LVL_X_LIMITS:  prdata = {32'd0, r_lvl_x_limits};
            pclf_pkg::REG_LVL_YZ_LIMITS: prdata = {16'd0, r_lvl_yz_limits};
            pclf_pkg::REG_EGO_ENABLE:    prdata = {63'd0, r_ego_enable};
            default:                     prdata = '0;
        endcase
    end

    assign w_rdy_out  = !r_out_valid || o_out.ready;
    assign w_rdy3     = !r_v3 || w_rdy_out;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;

    assign w_ctl.adv_prod = w_rdy2;
    assign w_ctl.adv_sum  = w_rdy3;

    always_comb begin
        w_pre_pass = (r_x1 >= $signed(r_pre_x_limits[15:0]))
                  && (r_x1 <= $signed(r_pre_x_limits[31:16]))
                  && (pclf_pkg::abs17(r_y1) <= pclf_pkg::sext17(r_pre_yz_limits[15:0]))
                  && (r_z1 < $signed(r_pre_yz_limits[31:16]));
        w_ego_hit  = r_ego_enable
                  && (r_x1 >= pclf_pkg::EGO_X_MIN) && (r_x1 <= pclf_pkg::EGO_X_MAX)
                  && (r_y1 >= pclf_pkg::EGO_Y_MIN) && (r_y1 <= pclf_pkg::EGO_Y_MAX)
                  && (r_z1 >= pclf_pkg::EGO_Z_MIN) && (r_z1 <= pclf_pkg::EGO_Z_MAX);
        w_lvl_pass = (w_lx >= $signed(r_lvl_x_limits[15:0]))
                  && (w_lx <= $signed(r_lvl_x_limits[31:16]))
                  && (pclf_pkg::abs17(w_ly) <= pclf_pkg::sext17(r_lvl_yz_limits[15:0]))
                  && (w_lz > $signed(r_lvl_yz_limits[31:16]))
                  && (w_lz < $signed(r_lvl_yz_limits[47:32]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in.valid && i_in.point_ok;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1 && w_pre_pass && !w_ego_hit;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy_out) begin
                r_out_valid <= r_v3 && w_lvl_pass;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_x1 <= i_in.body_x;
            r_y1 <= i_in.body_y;
            r_z1 <= i_in.body_z;
        end
        if (w_rdy_out) begin
            r_out_x <= w_lx;
            r_out_y <= w_ly;
            r_out_z <= w_lz;
        end
    end

    pclf_rot_row u_row_x (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_row   (r_rot_row_x),
        .i_x     (r_x1),
        .i_y     (r_y1),
        .i_z     (r_z1),
        .o_level (w_lx)
    );

    pclf_rot_row u_row_y (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_row   (r_rot_row_y),
        .i_x     (r_x1),
        .i_y     (r_y1),
        .i_z     (r_z1),
        .o_level (w_ly)
    );

    pclf_rot_row u_row_z (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_row   (r_rot_row_z),
        .i_x     (r_x1),
        .i_y     (r_y1),
        .i_z     (r_z1),
        .o_level (w_lz)
    );

    assign o_out.valid   = r_out_valid;
    assign o_out.level_x = r_out_x;
    assign o_out.level_y = r_out_y;
    assign o_out.level_z = r_out_z;

endmodule

@@ rtl/pclf_checker.sv @@
// Port-level checker of the point crop filter and its bind to the top level
`include "point_crop_and_level_filter_macros.svh"

module pclf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_level_x,
    input logic [15:0] i_level_y,
    input logic [15:0] i_level_z
);

    `PCLF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `PCLF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable({i_level_x, i_level_y, i_level_z}), "result changed while stalled")
    `PCLF_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with an empty output register")
    `PCLF_ASSERT_ALWAYS_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !i_out_valid, "result valid right after reset")

endmodule

bind point_crop_and_level_filter pclf_checker u_pclf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_level_x   (o_out.level_x),
    .i_level_y   (o_out.level_y),
    .i_level_z   (o_out.level_z)
);

@@ test/point_crop_and_level_filter_checker.sv @@
// Watches the point channels and the register port, predicts leveled points and compares them
module point_crop_and_level_filter_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pclf_in_if                               i_in,
    pclf_out_if                              i_out,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [pclf_pkg::PCLF_ADDR_W-1:0] i_paddr,
    input  logic [pclf_pkg::PCLF_DATA_W-1:0] i_pwdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [15:0] VEH_X_MIN = -16'sd250;
    localparam logic signed [15:0] VEH_X_MAX = 16'sd380;
    localparam logic signed [15:0] VEH_Y_MIN = -16'sd190;
    localparam logic signed [15:0] VEH_Y_MAX = 16'sd190;
    localparam logic signed [15:0] VEH_Z_MIN = -16'sd150;
    localparam logic signed [15:0] VEH_Z_MAX = 16'sd550;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_point;

    logic [47:0] row_x, row_y, row_z;
    logic [31:0] pre_x, pre_yz, lvl_x;
    logic [47:0] lvl_yz;
    logic        ego_on;

    t_point leveled_q[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic logic signed [15:0] rotate_axis(input logic [47:0] row,
                                                       input logic signed [15:0] px,
                                                       input logic signed [15:0] py,
                                                       input logic signed [15:0] pz);
        logic signed [63:0] acc;
        acc = $signed(row[15:0]) * px + $signed(row[31:16]) * py + $signed(row[47:32]) * pz;
        acc = acc >>> 14;
        if (acc > 64'sd32767) return 16'sh7fff;
        if (acc < -64'sd32768) return 16'sh8000;
        return acc[15:0];
    endfunction

    function automatic logic signed [16:0] magnitude(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = v;
        if (w < 0) w = -w;
        return w;
    endfunction

    function automatic bit level_point(input logic ok, input t_point body, output t_point lv);
        logic signed [15:0] bx, by, bz;
        bx = body.x;
        by = body.y;
        bz = body.z;
        lv = '0;
        if (!ok) return 0;
        if (bx < $signed(pre_x[15:0]) || bx > $signed(pre_x[31:16]) ||
            magnitude(by) > $signed(pre_yz[15:0]) || bz >= $signed(pre_yz[31:16])) begin
            return 0;
        end
        if (ego_on && bx >= VEH_X_MIN && bx <= VEH_X_MAX && by >= VEH_Y_MIN &&
            by <= VEH_Y_MAX && bz >= VEH_Z_MIN && bz <= VEH_Z_MAX) begin
            return 0;
        end
        lv.x = rotate_axis(row_x, bx, by, bz);
        lv.y = rotate_axis(row_y, bx, by, bz);
        lv.z = rotate_axis(row_z, bx, by, bz);
        if (lv.x < $signed(lvl_x[15:0]) || lv.x > $signed(lvl_x[31:16]) ||
            magnitude(lv.y) > $signed(lvl_yz[15:0]) ||
            lv.z <= $signed(lvl_yz[31:16]) || lv.z >= $signed(lvl_yz[47:32])) begin
            return 0;
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_point body, got, want, lv;
        if (!i_rst_n) begin
            row_x = pclf_pkg::RST_ROT_ROW_X;
            row_y = pclf_pkg::RST_ROT_ROW_Y;
            row_z = pclf_pkg::RST_ROT_ROW_Z;
            pre_x = pclf_pkg::RST_PRE_X_LIMITS;
            pre_yz = pclf_pkg::RST_PRE_YZ_LIMITS;
            lvl_x = pclf_pkg::RST_LVL_X_LIMITS;
            lvl_yz = pclf_pkg::RST_LVL_YZ_LIMITS;
            ego_on = pclf_pkg::RST_EGO_ENABLE;
            leveled_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (pclf_pkg::t_reg_idx'(i_paddr[pclf_pkg::PCLF_ADDR_W-1:3]))
                    pclf_pkg::REG_ROT_ROW_X:     row_x = i_pwdata[47:0];
                    pclf_pkg::REG_ROT_ROW_Y:     row_y = i_pwdata[47:0];
                    pclf_pkg::REG_ROT_ROW_Z:     row_z = i_pwdata[47:0];
                    pclf_pkg::REG_PRE_X_LIMITS:  pre_x = i_pwdata[31:0];
                    pclf_pkg::REG_PRE_YZ_LIMITS: pre_yz = i_pwdata[31:0];
                    pclf_pkg::REG_LVL_X_LIMITS:  lvl_x = i_pwdata[31:0];
                    pclf_pkg::REG_LVL_YZ_LIMITS: lvl_yz = i_pwdata[47:0];
                    pclf_pkg::REG_EGO_ENABLE:    ego_on = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.x = i_out.level_x;
                got.y = i_out.level_y;
                got.z = i_out.level_z;
                if (leveled_q.size() == 0) begin
                    report_mismatch("leveled point with none pending, x", got.x, 0);
                end else begin
                    want = leveled_q.pop_front();
                    if (got.x !== want.x) report_mismatch("level_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("level_y", got.y, want.y);
                    if (got.z !== want.z) report_mismatch("level_z", got.z, want.z);
                end
            end
            if (i_in.valid && i_in.ready) begin
                body.x = i_in.body_x;
                body.y = i_in.body_y;
                body.z = i_in.body_z;
                if (level_point(i_in.point_ok, body, lv)) leveled_q = {leveled_q, lv};
            end
        end
        o_pending = leveled_q.size();
    end

endmodule

@@ test/point_crop_and_level_filter_tb.sv @@
// Top of the point crop and level filter testbench: clock, reset, stimulus and verdict
module point_crop_and_level_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [pclf_pkg::PCLF_ADDR_W-1:0] paddr;
    logic [pclf_pkg::PCLF_DATA_W-1:0] pwdata;
    logic [pclf_pkg::PCLF_DATA_W-1:0] prdata;
    logic                             pready;

    int fail_count;
    int pending;
    bit no_gaps;
    bit hold_req;
    int aim_x_lo, aim_x_hi, aim_y, aim_z_lo, aim_z_hi;

    pclf_in_if  in_ch ();
    pclf_out_if out_ch ();

    point_crop_and_level_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    point_crop_and_level_filter_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin : receiver
        int hold_cnt;
        bit hold_done;
        hold_cnt = 0;
        hold_done = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_cnt = 120;
            end
            if (hold_cnt > 0) begin
                out_ch.ready <= 1'b0;
                hold_cnt--;
            end else begin
                out_ch.ready <= no_gaps || ($urandom_range(99, 0) >= 28);
            end
        end
    end

    function automatic logic signed [15:0] pick(input int lo, input int hi);
        return 16'(lo + int'($urandom_range(hi - lo, 0)));
    endfunction

    function automatic int corner();
        case ($urandom_range(5, 0))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic logic [31:0] pair16(input int lo, input int hi);
        return {hi[15:0], lo[15:0]};
    endfunction

    function automatic logic [47:0] trio48(input int a, input int b, input int c);
        return {c[15:0], b[15:0], a[15:0]};
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_point(input bit ok, input int x, input int y, input int z);
        while (!no_gaps && $urandom_range(99, 0) < 28) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.point_ok <= ok;
        in_ch.body_x   <= x[15:0];
        in_ch.body_y   <= y[15:0];
        in_ch.body_z   <= z[15:0];
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random(input int n);
        int kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(99, 0);
            if (kind < 70) begin
                send_point(1'b1, pick(aim_x_lo, aim_x_hi), pick(-aim_y, aim_y),
                           pick(aim_z_lo, aim_z_hi));
            end else if (kind < 82) begin
                send_point(1'b1, pick(-32768, 32767), pick(-32768, 32767),
                           pick(-32768, 32767));
            end else if (kind < 90) begin
                send_point(1'b0, pick(-32768, 32767), pick(-32768, 32767),
                           pick(-32768, 32767));
            end else begin
                send_point(1'b1, corner(), corner(), corner());
            end
        end
    endtask

    task automatic set_aim(input int xlo, input int xhi, input int y, input int zlo,
                           input int zhi);
        aim_x_lo = xlo;
        aim_x_hi = xhi;
        aim_y = y;
        aim_z_lo = zlo;
        aim_z_hi = zhi;
    endtask

    // Drop valid, wait for outstanding points, then let the pipeline empty
    task automatic drain_points();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
            guard++;
        end while (pending != 0 && guard < 5000);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input pclf_pkg::t_reg_idx idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [47:0] rx, input logic [47:0] ry,
                             input logic [47:0] rz, input logic [31:0] px,
                             input logic [31:0] pyz, input logic [31:0] lx,
                             input logic [47:0] lyz, input logic ego);
        drain_points();
        apb_write(pclf_pkg::REG_ROT_ROW_X, 64'(rx));
        apb_write(pclf_pkg::REG_ROT_ROW_Y, 64'(ry));
        apb_write(pclf_pkg::REG_ROT_ROW_Z, 64'(rz));
        apb_write(pclf_pkg::REG_PRE_X_LIMITS, 64'(px));
        apb_write(pclf_pkg::REG_PRE_YZ_LIMITS, 64'(pyz));
        apb_write(pclf_pkg::REG_LVL_X_LIMITS, 64'(lx));
        apb_write(pclf_pkg::REG_LVL_YZ_LIMITS, 64'(lyz));
        apb_write(pclf_pkg::REG_EGO_ENABLE, 64'(ego));
    endtask

    initial begin : stimulus
        logic [47:0] id_x, id_y, id_z, wide_lvl_yz;
        logic [31:0] wide_x, wide_pre_yz;
        id_x = trio48(16384, 0, 0);
        id_y = trio48(0, 16384, 0);
        id_z = trio48(0, 0, 16384);
        wide_x = pair16(-32768, 32767);
        wide_pre_yz = pair16(32767, 32767);
        wide_lvl_yz = trio48(32767, -32768, 32767);
        no_gaps = 0;
        hold_req = 0;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.point_ok <= 1'b0;
        in_ch.body_x   <= '0;
        in_ch.body_y   <= '0;
        in_ch.body_z   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: box edges, ego edges, invalid points, extremes
        send_point(1'b0, 1000, 0, 100);
        send_point(1'b1, 1000, 0, 100);
        send_point(1'b1, 0, 1000, 100);
        send_point(1'b1, 6000, 0, 100);
        send_point(1'b1, 6001, 0, 100);
        send_point(1'b1, -1, 1000, 100);
        send_point(1'b1, 3000, 1500, 100);
        send_point(1'b1, 3000, -1500, 100);
        send_point(1'b1, 3000, 1501, 100);
        send_point(1'b1, 3000, -32768, 100);
        send_point(1'b1, 3000, 0, 299);
        send_point(1'b1, 3000, 0, 300);
        send_point(1'b1, 3000, 0, 0);
        send_point(1'b1, 3000, 0, 1);
        send_point(1'b1, 380, 190, 100);
        send_point(1'b1, 381, 190, 100);
        send_point(1'b1, 200, -191, 100);
        send_point(1'b1, 200, 0, -150);
        send_point(1'b1, 32767, 32767, 32767);
        send_point(1'b1, -32768, -32768, -32768);

        // Open boxes, identity, ego removal off
        configure(id_x, id_y, id_z, wide_x, wide_pre_yz, wide_x, wide_lvl_yz, 1'b0);
        send_point(1'b1, -250, -190, -150);
        send_point(1'b1, -32768, -32767, -32767);
        send_point(1'b1, 32767, 32767, 32766);
        send_point(1'b1, 0, 0, 32767);
        send_point(1'b1, 0, -32768, 0);
        set_aim(-32768, 32767, 32767, -32768, 32767);
        no_gaps = 1;
        hold_req = 1;
        send_random(200);
        no_gaps = 0;
        send_random(100);

        // Open boxes with ego removal
        configure(id_x, id_y, id_z, wide_x, wide_pre_yz, wide_x, wide_lvl_yz, 1'b1);
        send_point(1'b1, -250, -190, -150);
        send_point(1'b1, -251, -190, -150);
        send_point(1'b1, 380, 190, 550);
        send_point(1'b1, 380, 190, 551);
        set_aim(-700, 900, 600, -600, 1000);
        send_random(200);

        // Full-scale matrix entries, saturate both ways
        configure(trio48(32767, 32767, 32767), trio48(-32768, -32768, -32768),
                  trio48(-32768, 0, 32767), wide_x, wide_pre_yz, wide_x, wide_lvl_yz, 1'b1);
        set_aim(-32768, 32767, 32767, -32768, 32767);
        send_random(100);

        // Random matrices
        configure(rand48(), rand48(), rand48(), wide_x, wide_pre_yz, wide_x, wide_lvl_yz,
                  1'b1);
        send_random(100);
        configure(rand48(), rand48(), rand48(), wide_x, wide_pre_yz, wide_x, wide_lvl_yz,
                  1'b0);
        send_random(100);

        // Inverted and empty boxes
        configure(id_x, id_y, id_z, pair16(100, -100), pair16(-1, 32767),
                  pair16(32767, -32768), trio48(-1, 32767, -32768), 1'b1);
        send_random(40);
        configure(rand48(), rand48(), rand48(), $urandom, $urandom, $urandom, rand48(), 1'b0);
        send_random(60);
        configure(48'h0, 48'hffff_ffff_ffff, 48'h0, 32'h0, 32'hffff_ffff, 32'h0,
                  48'hffff_ffff_ffff, 1'b0);
        send_random(40);

        // Small tilts around the nominal boxes
        configure(trio48(16300, pick(-900, 900), pick(-900, 900)),
                  trio48(pick(-900, 900), 16300, pick(-900, 900)),
                  trio48(pick(-900, 900), pick(-900, 900), 16300),
                  pair16(0, 6000), pair16(1500, 300), pair16(0, 6000),
                  trio48(1500, 0, 300), 1'b1);
        set_aim(-400, 6500, 1700, -200, 400);
        send_random(250);
        configure(trio48(16200, pick(-1500, 1500), pick(-1500, 1500)),
                  trio48(pick(-1500, 1500), 16200, pick(-1500, 1500)),
                  trio48(pick(-1500, 1500), pick(-1500, 1500), 16200),
                  pair16(-2000, 8000), pair16(3000, 1500), pair16(-1500, 7000),
                  trio48(2500, -500, 1200), 1'b1);
        set_aim(-2500, 8500, 3200, -800, 1600);
        send_random(120);

        drain_points();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
